### rtl/core/dsdc_pkg.sv
// ----------------------------------------------------------------------------
// dsdc_pkg
// Shared types, widths and month tables for the calendar day-number unit.
// ----------------------------------------------------------------------------
package dsdc_pkg;

  localparam int MAX_YEAR_DEF = 9999;

  localparam int OP_W    = 3;
  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int SER_W   = 22;

  // internal serial width, wide enough for the last day of any allowed year
  localparam int SER_IW  = 25;
  // quotient bits of the four-year cycle count
  localparam int QUO_W   = 14;
  // day offset inside one year
  localparam int DOY_W   = 9;

  localparam int CYCLE_DAYS = 1461;
  localparam int YEAR_DAYS  = 365;
  localparam int LEAP_DAYS  = 366;

  localparam int QDEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TO_SERIAL   = 3'd0,
    OP_FROM_SERIAL = 3'd1,
    OP_NEXT_DAY    = 3'd2,
    OP_PREV_DAY    = 3'd3,
    OP_DURATION    = 3'd4
  } op_t;

  typedef struct packed {
    logic              conv;
    logic              err;
    logic [SER_IW-1:0] val;
  } job_t;

  // days of the months before month m
  function automatic logic [DOY_W-1:0] month_cum(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DOY_W-1:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m > 4'd2) && (m <= 4'd12)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

### rtl/core/dsdc_front.sv
// ----------------------------------------------------------------------------
// dsdc_front
// Takes requests, checks the dates, forms serials and classifies each request
// into a finished result or a serial-to-date job for the back end.
// ----------------------------------------------------------------------------
module dsdc_front #(
  parameter int MAX_YEAR = dsdc_pkg::MAX_YEAR_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dsdc_pkg::OP_W-1:0]    in_operation,
  input  logic [dsdc_pkg::DAY_W-1:0]   in_day,
  input  logic [dsdc_pkg::MON_W-1:0]   in_month,
  input  logic [dsdc_pkg::YEAR_W-1:0]  in_year,
  input  logic [dsdc_pkg::SER_W-1:0]   in_serial_in,
  input  logic [dsdc_pkg::DAY_W-1:0]   in_other_day,
  input  logic [dsdc_pkg::MON_W-1:0]   in_other_month,
  input  logic [dsdc_pkg::YEAR_W-1:0]  in_other_year,
  output logic                         q_valid,
  input  logic                         q_ready,
  output dsdc_pkg::job_t               q_job
);

  localparam int SW = dsdc_pkg::SER_IW;
  localparam logic [16:0] MAXY = 17'(MAX_YEAR);
  localparam int TOP_I = 365 * MAX_YEAR + (MAX_YEAR + 3) / 4 + 365 +
                         (((MAX_YEAR % 4) == 0) ? 1 : 0);
  localparam logic [SW-1:0] TOP_S = SW'(TOP_I);

  function automatic logic [SW-1:0] to_serial(
    input logic [dsdc_pkg::DAY_W-1:0]  d,
    input logic [dsdc_pkg::MON_W-1:0]  m,
    input logic [dsdc_pkg::YEAR_W-1:0] y
  );
    logic leap;
    logic [SW-1:0] s;
    leap = (y[1:0] == 2'b00);
    s = SW'(d) + SW'(y) * SW'(dsdc_pkg::YEAR_DAYS)
      + SW'(({1'b0, y} + 15'd3) >> 2)
      + SW'(dsdc_pkg::month_cum(m, leap));
    return s;
  endfunction

  function automatic logic date_ok(
    input logic [dsdc_pkg::DAY_W-1:0]  d,
    input logic [dsdc_pkg::MON_W-1:0]  m,
    input logic [dsdc_pkg::YEAR_W-1:0] y
  );
    logic leap;
    leap = (y[1:0] == 2'b00);
    return (m >= 4'd1) && (m <= 4'd12) && (d != 5'd0) &&
           (d <= dsdc_pkg::month_len(m, leap)) && ({3'b000, y} <= MAXY);
  endfunction

  logic                        s1_vld_r;
  dsdc_pkg::op_t               s1_op_r;
  logic [SW-1:0]               s1_a_r;
  logic [SW-1:0]               s1_b_r;
  logic                        s1_va_r;
  logic                        s1_vb_r;
  logic [dsdc_pkg::SER_W-1:0]  s1_sin_r;

  logic                        s1_vld_nxt;
  dsdc_pkg::job_t              job;
  logic [SW-1:0]               sin_w;

  assign in_ready   = !s1_vld_r || q_ready;
  assign s1_vld_nxt = in_ready ? in_valid : s1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r  <= dsdc_pkg::op_t'(in_operation);
      s1_a_r   <= to_serial(in_day, in_month, in_year);
      s1_b_r   <= to_serial(in_other_day, in_other_month, in_other_year);
      s1_va_r  <= date_ok(in_day, in_month, in_year);
      s1_vb_r  <= date_ok(in_other_day, in_other_month, in_other_year);
      s1_sin_r <= in_serial_in;
    end
  end

  assign sin_w = SW'(s1_sin_r);

  always_comb begin
    job.conv = 1'b0;
    job.err  = 1'b0;
    job.val  = '0;
    case (s1_op_r)
      dsdc_pkg::OP_TO_SERIAL: begin
        job.err = !s1_va_r;
        job.val = s1_a_r;
      end
      dsdc_pkg::OP_FROM_SERIAL: begin
        job.err = (sin_w == '0) || (sin_w > TOP_S);
        job.val = sin_w - SW'(1);
      end
      dsdc_pkg::OP_NEXT_DAY: begin
        job.err = !s1_va_r || (s1_a_r >= TOP_S);
        job.val = s1_a_r;
      end
      dsdc_pkg::OP_PREV_DAY: begin
        job.err = !s1_va_r || (s1_a_r <= SW'(1));
        job.val = s1_a_r - SW'(2);
      end
      dsdc_pkg::OP_DURATION: begin
        job.err = !(s1_va_r && s1_vb_r);
        job.val = (s1_a_r > s1_b_r) ? (s1_a_r - s1_b_r) : (s1_b_r - s1_a_r);
      end
      default: begin
        job.err = 1'b1;
      end
    endcase
    job.conv = !job.err && (s1_op_r inside {dsdc_pkg::OP_FROM_SERIAL,
                                            dsdc_pkg::OP_NEXT_DAY,
                                            dsdc_pkg::OP_PREV_DAY});
  end

  assign q_valid = s1_vld_r;
  assign q_job   = job;

endmodule

### rtl/core/dsdc_queue.sv
// ----------------------------------------------------------------------------
// dsdc_queue
// Short register queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module dsdc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  dsdc_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output dsdc_pkg::job_t rd_job
);

  localparam int DEPTH = dsdc_pkg::QDEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  dsdc_pkg::job_t  mem_r [DEPTH];
  logic [PW-1:0]   wp_r;
  logic [PW-1:0]   rp_r;
  logic [CW-1:0]   cnt_r;
  logic [PW-1:0]   wp_nxt;
  logic [PW-1:0]   rp_nxt;
  logic [CW-1:0]   cnt_nxt;
  logic            wr_go;
  logic            rd_go;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rp_r];
  assign wr_go    = wr_valid && wr_ready;
  assign rd_go    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_go) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (rd_go) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (wr_go && !rd_go) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (rd_go && !wr_go) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem_r[wp_r] <= wr_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_go && !rd_go) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("queue fill count missed a write");
`endif

endmodule

### rtl/core/dsdc_back.sv
// ----------------------------------------------------------------------------
// dsdc_back
// Runs serial-to-date jobs with a reciprocal divide by the four-year cycle and
// a month search, and holds the result register of the output channel.
// ----------------------------------------------------------------------------
module dsdc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  dsdc_pkg::job_t               q_job,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dsdc_pkg::DAY_W-1:0]   out_day,
  output logic [dsdc_pkg::MON_W-1:0]   out_month,
  output logic [dsdc_pkg::YEAR_W-1:0]  out_year,
  output logic [dsdc_pkg::SER_W-1:0]   out_serial,
  output logic                         out_error
);

  localparam int SW  = dsdc_pkg::SER_IW;
  localparam int QW  = dsdc_pkg::QUO_W;
  localparam int YW  = QW + 2;
  localparam int DW  = dsdc_pkg::DOY_W;
  localparam int RSH = SW + $clog2(dsdc_pkg::CYCLE_DAYS);
  localparam int RW  = SW + 1;
  localparam logic [63:0] RECIP_W = ((64'd1 << RSH) + 64'(dsdc_pkg::CYCLE_DAYS) - 64'd1) /
                                    64'(dsdc_pkg::CYCLE_DAYS);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_W);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_REM   = 6'b000100,
    ST_YEAR  = 6'b001000,
    ST_MONTH = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t                       st_r,  st_nxt;
  logic [SW-1:0]                rem_r, rem_nxt;
  logic [QW-1:0]                quo_r, quo_nxt;
  logic [YW-1:0]                yr_r,  yr_nxt;
  logic                         leap_r, leap_nxt;
  logic [dsdc_pkg::MON_W-1:0]   mon_r, mon_nxt;

  logic                         ovld_r, ovld_nxt;
  logic [dsdc_pkg::DAY_W-1:0]   oday_r, oday_nxt;
  logic [dsdc_pkg::MON_W-1:0]   omon_r, omon_nxt;
  logic [dsdc_pkg::YEAR_W-1:0]  oyear_r, oyear_nxt;
  logic [dsdc_pkg::SER_W-1:0]   oser_r, oser_nxt;
  logic                         oerr_r, oerr_nxt;

  logic                         out_free;
  logic [SW+RW-1:0]             prod;
  logic [10:0]                  r11;
  logic [10:0]                  r2;
  logic [10:0]                  r3;
  logic [1:0]                   yoff;
  logic [DW-1:0]                doy;

  assign out_free = !ovld_r || out_ready;
  assign q_ready  = (st_r == ST_IDLE) && out_free;
  assign prod     = (SW+RW)'(rem_r) * (SW+RW)'(RECIP);
  assign r11      = rem_r[10:0];
  assign r2       = r11 - 11'(dsdc_pkg::LEAP_DAYS);
  assign doy      = rem_r[DW-1:0];

  always_comb begin
    if (r11 < 11'(dsdc_pkg::LEAP_DAYS)) begin
      yoff = 2'd0;
      r3   = r11;
    end else if (r2 >= 11'(2 * dsdc_pkg::YEAR_DAYS)) begin
      yoff = 2'd3;
      r3   = r2 - 11'(2 * dsdc_pkg::YEAR_DAYS);
    end else if (r2 >= 11'(dsdc_pkg::YEAR_DAYS)) begin
      yoff = 2'd2;
      r3   = r2 - 11'(dsdc_pkg::YEAR_DAYS);
    end else begin
      yoff = 2'd1;
      r3   = r2;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    yr_nxt    = yr_r;
    leap_nxt  = leap_r;
    mon_nxt   = mon_r;
    ovld_nxt  = ovld_r;
    oday_nxt  = oday_r;
    omon_nxt  = omon_r;
    oyear_nxt = oyear_r;
    oser_nxt  = oser_r;
    oerr_nxt  = oerr_r;
    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (q_valid && q_ready) begin
          if (q_job.conv) begin
            rem_nxt = q_job.val;
            quo_nxt = '0;
            st_nxt  = ST_DIV;
          end else begin
            ovld_nxt  = 1'b1;
            oday_nxt  = '0;
            omon_nxt  = '0;
            oyear_nxt = '0;
            oser_nxt  = q_job.err ? '0 : q_job.val[dsdc_pkg::SER_W-1:0];
            oerr_nxt  = q_job.err;
          end
        end
      end
      ST_DIV: begin
        quo_nxt = prod[RSH +: QW];
        st_nxt  = ST_REM;
      end
      ST_REM: begin
        rem_nxt = rem_r - SW'(quo_r) * SW'(dsdc_pkg::CYCLE_DAYS);
        st_nxt  = ST_YEAR;
      end
      ST_YEAR: begin
        yr_nxt   = {quo_r, 2'b00} + YW'(yoff);
        leap_nxt = (yoff == 2'd0);
        rem_nxt  = SW'(r3);
        st_nxt   = ST_MONTH;
      end
      ST_MONTH: begin
        mon_nxt = 4'd1;
        for (int i = 2; i <= 12; i++) begin
          if (doy >= dsdc_pkg::month_cum(4'(i), leap_r)) begin
            mon_nxt = 4'(i);
          end
        end
        st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          oday_nxt  = dsdc_pkg::DAY_W'(doy - dsdc_pkg::month_cum(mon_r, leap_r) + 9'd1);
          omon_nxt  = mon_r;
          oyear_nxt = yr_r[dsdc_pkg::YEAR_W-1:0];
          oser_nxt  = '0;
          oerr_nxt  = 1'b0;
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    yr_r    <= yr_nxt;
    leap_r  <= leap_nxt;
    mon_r   <= mon_nxt;
    oday_r  <= oday_nxt;
    omon_r  <= omon_nxt;
    oyear_r <= oyear_nxt;
    oser_r  <= oser_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign out_valid  = ovld_r;
  assign out_day    = oday_r;
  assign out_month  = omon_r;
  assign out_year   = oyear_r;
  assign out_serial = oser_r;
  assign out_error  = oerr_r;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && oerr_r) |-> (oday_r == '0 && omon_r == '0 &&
                            oyear_r == '0 && oser_r == '0))
    else $error("error result carries non-zero fields");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && (oday_r != '0)) |-> (omon_r >= 4'd1 && omon_r <= 4'd12 &&
                                    oday_r <= 5'd31))
    else $error("converted date out of range");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |=> (st_r == ST_REM))
    else $error("divider did not hand over to remainder step");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_YEAR) |-> (rem_r < SW'(dsdc_pkg::CYCLE_DAYS)))
    else $error("remainder beyond one four-year cycle");
`endif

endmodule

### rtl/core/date_serial_day_converter_unit.sv
// Path: front-end register, job queue, back-end result register; serial to date, next
//   and previous day first run the back-end divide, remainder, year and month steps.
// Throughput: one non-converting request per cycle while the back end is idle and
//   the output accepts; the back end takes no job until a conversion result is written.
// Reset: rst_n synchronous, active low; clears handshakes, queue and sequencer.
// ----------------------------------------------------------------------------
// date_serial_day_converter_unit
// Calendar day-number unit with the every-fourth-year leap rule: date to
// serial, serial to date, next and previous day, and distance between dates.
// ----------------------------------------------------------------------------
module date_serial_day_converter_unit #(
  parameter int MAX_YEAR = dsdc_pkg::MAX_YEAR_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dsdc_pkg::OP_W-1:0]    in_operation,
  input  logic [dsdc_pkg::DAY_W-1:0]   in_day,
  input  logic [dsdc_pkg::MON_W-1:0]   in_month,
  input  logic [dsdc_pkg::YEAR_W-1:0]  in_year,
  input  logic [dsdc_pkg::SER_W-1:0]   in_serial_in,
  input  logic [dsdc_pkg::DAY_W-1:0]   in_other_day,
  input  logic [dsdc_pkg::MON_W-1:0]   in_other_month,
  input  logic [dsdc_pkg::YEAR_W-1:0]  in_other_year,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dsdc_pkg::DAY_W-1:0]   out_day,
  output logic [dsdc_pkg::MON_W-1:0]   out_month,
  output logic [dsdc_pkg::YEAR_W-1:0]  out_year,
  output logic [dsdc_pkg::SER_W-1:0]   out_serial,
  output logic                         out_error
);

  logic           fq_valid;
  logic           fq_ready;
  dsdc_pkg::job_t fq_job;
  logic           qb_valid;
  logic           qb_ready;
  dsdc_pkg::job_t qb_job;

  dsdc_front #(
    .MAX_YEAR (MAX_YEAR)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year        (in_year),
    .in_serial_in   (in_serial_in),
    .in_other_day   (in_other_day),
    .in_other_month (in_other_month),
    .in_other_year  (in_other_year),
    .q_valid        (fq_valid),
    .q_ready        (fq_ready),
    .q_job          (fq_job)
  );

  dsdc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_job   (fq_job),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_job   (qb_job)
  );

  dsdc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_job      (qb_job),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_day    (out_day),
    .out_month  (out_month),
    .out_year   (out_year),
    .out_serial (out_serial),
    .out_error  (out_error)
  );

endmodule

### verif/date_serial_day_converter_unit_tb.sv
// ----------------------------------------------------------------------------
// date_serial_day_converter_unit_tb
// Self-checking bench for the calendar day-number unit. Requests come from a
// queue filled by directed cases and random batches and are driven with
// random gaps; the result side stalls at random. Every accepted request is
// run through a behavioural calendar model and each result is compared field
// by field in order.
// ----------------------------------------------------------------------------
module date_serial_day_converter_unit_tb;
  import dsdc_pkg::*;

  localparam int MAX_YEAR = MAX_YEAR_DEF;
  localparam logic [OP_W-1:0] OP_LAST_CODE = '1;
  localparam int RANDOM_BATCHES = 25;
  localparam int BATCH_SIZE = 50;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [SER_W-1:0]  serial;
    logic [DAY_W-1:0]  other_day;
    logic [MON_W-1:0]  other_month;
    logic [YEAR_W-1:0] other_year;
  } date_request_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [SER_W-1:0]  serial;
    logic              error;
  } date_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation = '0;
  logic [DAY_W-1:0]  in_day = '0;
  logic [MON_W-1:0]  in_month = '0;
  logic [YEAR_W-1:0] in_year = '0;
  logic [SER_W-1:0]  in_serial_in = '0;
  logic [DAY_W-1:0]  in_other_day = '0;
  logic [MON_W-1:0]  in_other_month = '0;
  logic [YEAR_W-1:0] in_other_year = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DAY_W-1:0]  out_day;
  logic [MON_W-1:0]  out_month;
  logic [YEAR_W-1:0] out_year;
  logic [SER_W-1:0]  out_serial;
  logic              out_error;

  date_request_t pending_requests[$];
  date_result_t  expected_dates[$];
  date_request_t active_request;
  logic          calm = 1'b0;
  int unsigned   send_gap = 0;
  int unsigned   ready_stall = 0;
  int unsigned   mismatches = 0;
  int unsigned   results_seen = 0;
  int unsigned   errors_seen = 0;
  int unsigned   ops_sent[2**OP_W];

  date_serial_day_converter_unit #(
    .MAX_YEAR(MAX_YEAR)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_day        (in_day),
    .in_month      (in_month),
    .in_year       (in_year),
    .in_serial_in  (in_serial_in),
    .in_other_day  (in_other_day),
    .in_other_month(in_other_month),
    .in_other_year (in_other_year),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_day       (out_day),
    .out_month     (out_month),
    .out_year      (out_year),
    .out_serial    (out_serial),
    .out_error     (out_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    if (m == 2) begin
      return (y % 4 == 0) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic logic date_ok(input int unsigned d, input int unsigned m,
                                   input int unsigned y);
    if (m < 1 || m > 12 || y > MAX_YEAR || d < 1) begin
      return 1'b0;
    end
    return d <= month_days(m, y);
  endfunction

  function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned sn;
    sn = d + YEAR_DAYS * y + (y + 3) / 4;
    for (int unsigned i = 1; i < m; i++) begin
      sn += month_days(i, y);
    end
    return sn;
  endfunction

  function automatic void serial_to_date(input int unsigned sn, output int unsigned d,
                                         output int unsigned m, output int unsigned y);
    int unsigned rest;
    rest = sn - 1;
    y = (rest / CYCLE_DAYS) * 4;
    rest = rest % CYCLE_DAYS;
    if (rest >= LEAP_DAYS) begin
      rest -= LEAP_DAYS;
      y += 1 + rest / YEAR_DAYS;
      rest = rest % YEAR_DAYS;
    end
    m = 1;
    while (m < 12 && rest >= month_days(m, y)) begin
      rest -= month_days(m, y);
      m++;
    end
    d = rest + 1;
  endfunction

  function automatic date_result_t calendar_result(input date_request_t q);
    date_result_t res;
    int unsigned  last, sn, a, b, rd, rm, ry, span_days;
    logic         bad;
    bad = 1'b0;
    rd = 0;
    rm = 0;
    ry = 0;
    span_days = 0;
    last = day_number(31, 12, MAX_YEAR);
    case (q.op)
      OP_TO_SERIAL: begin
        if (date_ok(q.day, q.month, q.year)) begin
          span_days = day_number(q.day, q.month, q.year);
        end else begin
          bad = 1'b1;
        end
      end
      OP_FROM_SERIAL: begin
        if (q.serial >= 1 && q.serial <= last) begin
          serial_to_date(q.serial, rd, rm, ry);
        end else begin
          bad = 1'b1;
        end
      end
      OP_NEXT_DAY, OP_PREV_DAY: begin
        if (!date_ok(q.day, q.month, q.year)) begin
          bad = 1'b1;
        end else begin
          sn = day_number(q.day, q.month, q.year);
          if (q.op == OP_NEXT_DAY) begin
            if (sn >= last) bad = 1'b1;
            else sn += 1;
          end else begin
            if (sn <= 1) bad = 1'b1;
            else sn -= 1;
          end
          if (!bad) serial_to_date(sn, rd, rm, ry);
        end
      end
      OP_DURATION: begin
        if (date_ok(q.day, q.month, q.year) &&
            date_ok(q.other_day, q.other_month, q.other_year)) begin
          a = day_number(q.day, q.month, q.year);
          b = day_number(q.other_day, q.other_month, q.other_year);
          span_days = (a > b) ? a - b : b - a;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      res = '0;
      res.error = 1'b1;
    end else begin
      res.day    = DAY_W'(rd);
      res.month  = MON_W'(rm);
      res.year   = YEAR_W'(ry);
      res.serial = SER_W'(span_days);
      res.error  = 1'b0;
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_request(input logic [OP_W-1:0] op, input int unsigned d,
                              input int unsigned m, input int unsigned y,
                              input int unsigned s, input int unsigned od,
                              input int unsigned om, input int unsigned oy);
    date_request_t q;
    q.op          = op;
    q.day         = DAY_W'(d);
    q.month       = MON_W'(m);
    q.year        = YEAR_W'(y);
    q.serial      = SER_W'(s);
    q.other_day   = DAY_W'(od);
    q.other_month = MON_W'(om);
    q.other_year  = YEAR_W'(oy);
    pending_requests.push_back(q);
  endtask

  // mostly valid dates biased to month ends and year extremes, some raw bits
  task automatic pick_date(output int unsigned d, output int unsigned m,
                           output int unsigned y);
    int unsigned pick, len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      d = $urandom_range(0, 2**DAY_W - 1);
      m = $urandom_range(0, 2**MON_W - 1);
      y = $urandom_range(0, 2**YEAR_W - 1);
    end else begin
      if (pick < 20) begin
        y = $urandom_range(0, 1) ? $urandom_range(0, 8) : MAX_YEAR - $urandom_range(0, 8);
      end else begin
        y = $urandom_range(0, MAX_YEAR);
      end
      m = $urandom_range(1, 12);
      len = month_days(m, y);
      pick = $urandom_range(0, 19);
      if (pick < 4) d = len;
      else if (pick < 6) d = 1;
      else if (pick == 6) d = len + 1;
      else d = $urandom_range(1, len);
    end
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || in_valid || expected_dates.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_dates.push_back(calendar_result(active_request));
        ops_sent[active_request.op]++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_requests.size() != 0) begin
          active_request = pending_requests.pop_front();
          in_operation   <= active_request.op;
          in_day         <= active_request.day;
          in_month       <= active_request.month;
          in_year        <= active_request.year;
          in_serial_in   <= active_request.serial;
          in_other_day   <= active_request.other_day;
          in_other_month <= active_request.other_month;
          in_other_year  <= active_request.other_year;
          in_valid       <= 1'b1;
          send_gap       <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    date_result_t want;
    if (!rst_n) begin
      out_ready   <= 1'b0;
      ready_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_error) errors_seen++;
        if (expected_dates.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual %0d/%0d/%0d serial %0d error %0b",
                   $time, out_day, out_month, out_year, out_serial, out_error);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          compare_field("day", want.day, out_day);
          compare_field("month", want.month, out_month);
          compare_field("year", want.year, out_year);
          compare_field("serial", want.serial, out_serial);
          compare_field("error", want.error, out_error);
        end
      end
      if (ready_stall != 0) begin
        out_ready   <= 1'b0;
        ready_stall <= ready_stall - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready   <= 1'b0;
        ready_stall <= pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned last, pick, d, m, y, s, od, om, oy, unknown_ops, failures;
    logic [OP_W-1:0] op;
    last = day_number(31, 12, MAX_YEAR);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    push_request(OP_TO_SERIAL, 1, 1, 0, 0, 0, 0, 0);
    push_request(OP_TO_SERIAL, 31, 12, MAX_YEAR, 0, 0, 0, 0);
    push_request(OP_TO_SERIAL, 29, 2, 2024, 0, 0, 0, 0);
    push_request(OP_TO_SERIAL, 29, 2, 2023, 0, 0, 0, 0);
    push_request(OP_TO_SERIAL, 0, 5, 100, 0, 0, 0, 0);
    push_request(OP_TO_SERIAL, 1, 0, 100, 0, 0, 0, 0);
    push_request(OP_TO_SERIAL, 31, 13, 100, 0, 0, 0, 0);
    push_request(OP_TO_SERIAL, 1, 1, MAX_YEAR + 1, 0, 0, 0, 0);
    push_request(OP_TO_SERIAL, 31, 15, 2**YEAR_W - 1, 2**SER_W - 1, 31, 15, 2**YEAR_W - 1);
    push_request(OP_FROM_SERIAL, 0, 0, 0, 0, 0, 0, 0);
    push_request(OP_FROM_SERIAL, 0, 0, 0, 1, 0, 0, 0);
    push_request(OP_FROM_SERIAL, 0, 0, 0, 60, 0, 0, 0);
    push_request(OP_FROM_SERIAL, 0, 0, 0, LEAP_DAYS, 0, 0, 0);
    push_request(OP_FROM_SERIAL, 0, 0, 0, CYCLE_DAYS, 0, 0, 0);
    push_request(OP_FROM_SERIAL, 0, 0, 0, last, 0, 0, 0);
    push_request(OP_FROM_SERIAL, 0, 0, 0, last + 1, 0, 0, 0);
    push_request(OP_FROM_SERIAL, 0, 0, 0, 2**SER_W - 1, 0, 0, 0);
    push_request(OP_NEXT_DAY, 31, 12, MAX_YEAR, 0, 0, 0, 0);
    push_request(OP_NEXT_DAY, 28, 2, 2024, 0, 0, 0, 0);
    push_request(OP_NEXT_DAY, 31, 1, 5, 0, 0, 0, 0);
    push_request(OP_PREV_DAY, 1, 1, 0, 0, 0, 0, 0);
    push_request(OP_PREV_DAY, 1, 3, 2024, 0, 0, 0, 0);
    push_request(OP_PREV_DAY, 1, 1, 1, 0, 0, 0, 0);
    push_request(OP_DURATION, 1, 1, 0, 0, 31, 12, MAX_YEAR);
    push_request(OP_DURATION, 31, 12, MAX_YEAR, 0, 1, 1, 0);
    push_request(OP_DURATION, 1, 1, 2000, 0, 31, 4, 2000);
    push_request(OP_W'(int'(OP_DURATION) + 1), 1, 1, 2000, 1000, 1, 1, 2000);
    push_request(OP_LAST_CODE, 1, 1, 2000, 1000, 1, 1, 2000);
    wait_until_drained();

    for (int b = 0; b < RANDOM_BATCHES; b++) begin
      while (pending_requests.size() != 0) @(negedge clk);
      calm = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < BATCH_SIZE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) op = OP_W'($urandom_range(int'(OP_LAST_CODE), int'(OP_DURATION) + 1));
        else op = OP_W'(pick % (int'(OP_DURATION) + 1));
        pick_date(d, m, y);
        pick_date(od, om, oy);
        s = $urandom_range(0, 2**SER_W - 1);
        if (op == OP_FROM_SERIAL) begin
          pick = $urandom_range(0, 99);
          if (pick < 55) begin
            s = $urandom_range(1, last);
          end else if (pick < 80) begin
            // last day of a month or the first of the next
            y = $urandom_range(0, MAX_YEAR);
            m = $urandom_range(1, 12);
            s = day_number(month_days(m, y), m, y) + $urandom_range(0, 1);
          end else if (pick < 90) begin
            s = $urandom_range(0, 1) ? $urandom_range(0, 2) : last - 1 + $urandom_range(0, 2);
          end
        end
        push_request(op, d, m, y, s, od, om, oy);
      end
      if (b % 5 == 4) wait_until_drained();
    end

    wait_until_drained();
    repeat (40) @(negedge clk);
    unknown_ops = 0;
    for (int i = int'(OP_DURATION) + 1; i <= int'(OP_LAST_CODE); i++) begin
      unknown_ops += ops_sent[i];
    end
    failures = mismatches + expected_dates.size();
    $display("checked %0d results, %0d of them flagged as errors, %0d mismatches",
             results_seen, errors_seen, failures);
    $display("requests: to serial %0d, from serial %0d, next %0d, previous %0d, duration %0d, unknown %0d",
             ops_sent[OP_TO_SERIAL], ops_sent[OP_FROM_SERIAL], ops_sent[OP_NEXT_DAY],
             ops_sent[OP_PREV_DAY], ops_sent[OP_DURATION], unknown_ops);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("FAILURE");
    $finish;
  end

endmodule
